### hw/rtl/pprb_pkg.sv
// Shared types and constants of the ping-pong receive buffer.
package pprb_pkg;

    // Widths of the word fields.
    localparam int ACTION_W = 3;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 6;

    // Action codes as they arrive on the input channel.
    typedef enum logic [ACTION_W-1:0] {
        ACT_RX      = 3'd0,
        ACT_DONE    = 3'd1,
        ACT_RELEASE = 3'd2,
        ACT_READ    = 3'd3,
        ACT_RESTART = 3'd4
    } t_action;

    // Decoded operation handed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_RX,
        OP_DONE,
        OP_RELEASE,
        OP_READ,
        OP_RESTART,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [BYTE_W-1:0]  data;
        logic               sel;
        logic [INDEX_W-1:0] idx;
        logic               read_ok;
    } t_cmd;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EMIT
    } t_bstate;

endpackage

### hw/rtl/pprb_if.sv
// Handshake interfaces of the input and result channels.
interface pprb_in_if;
    logic                             valid;
    logic                             ready;
    logic [pprb_pkg::ACTION_W-1:0]    action;
    logic [pprb_pkg::BYTE_W-1:0]      rx_byte;
    logic                             slot_select;
    logic [pprb_pkg::INDEX_W-1:0]     read_index;

    modport source (output valid, action, rx_byte, slot_select, read_index, input ready);
    modport sink   (input valid, action, rx_byte, slot_select, read_index, output ready);
endinterface

interface pprb_out_if;
    logic                             valid;
    logic                             ready;
    logic [pprb_pkg::BYTE_W-1:0]      read_data;
    logic                             current_slot;
    logic [pprb_pkg::COUNT_W-1:0]     fill_count;
    logic                             swapped;
    logic                             dropped;

    modport source (output valid, read_data, current_slot, fill_count, swapped, dropped,
                    input ready);
    modport sink   (input valid, read_data, current_slot, fill_count, swapped, dropped,
                    output ready);
endinterface

### hw/rtl/pprb_front.sv
// Front end: accepts input words, decodes the action and range-checks reads.
module pprb_front #(
    parameter int SLOT_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pprb_in_if.sink             i_in,
    input  logic                i_init_busy,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output pprb_pkg::t_cmd      o_cmd
);
    import pprb_pkg::*;

    localparam int XW = 9;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic w_take;

    // Hold off new words during the power-up clear and while the register is blocked.
    assign i_in.ready  = (!r_valid || i_cmd_ready) && !i_init_busy;
    assign w_take      = i_in.valid && i_in.ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Decode the action code into an operation.
    always_comb begin
        n_cmd.data    = i_in.rx_byte;
        n_cmd.sel     = i_in.slot_select;
        n_cmd.idx     = i_in.read_index;
        n_cmd.read_ok = XW'(i_in.read_index) < XW'(SLOT_BYTES);
        case (i_in.action)
            ACT_RX:      n_cmd.op = OP_RX;
            ACT_DONE:    n_cmd.op = OP_DONE;
            ACT_RELEASE: n_cmd.op = OP_RELEASE;
            ACT_READ:    n_cmd.op = OP_READ;
            ACT_RESTART: n_cmd.op = OP_RESTART;
            default:     n_cmd.op = OP_NOP;
        endcase
    end

    // Output register toward the command queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

### hw/rtl/pprb_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
module pprb_cmd_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  pprb_pkg::t_cmd      i_cmd,
    output logic                o_valid,
    input  logic                i_ready,
    output pprb_pkg::t_cmd      o_cmd
);
    import pprb_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

### hw/rtl/pprb_back.sv
// Back end: slot memory, fill counts, release flags, clear sweeps and the result register.
module pprb_back #(
    parameter int SLOT_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  pprb_pkg::t_cmd      i_cmd,
    output logic                o_init_busy,
    pprb_out_if.source          o_out
);
    import pprb_pkg::*;

    localparam int AW = $clog2(SLOT_BYTES);
    localparam int XW = 9;
    localparam int DEPTH = 2 << AW;
    localparam logic [AW-1:0] LAST = AW'(SLOT_BYTES - 1);

    // Slot memory, addressed by {slot, offset}.
    logic [BYTE_W-1:0] r_mem [DEPTH];

    t_bstate           r_state, n_state;
    logic              r_active, n_active;
    logic [1:0]        r_rel, n_rel;
    logic [AW-1:0]     r_cnt [2];
    logic [AW-1:0]     n_cnt [2];
    logic              r_clr_slot, n_clr_slot;
    logic              r_clr_both, n_clr_both;
    logic [AW-1:0]     r_clr_ptr, n_clr_ptr;
    logic              r_swap, n_swap;
    logic              r_drop, n_drop;
    logic              r_rd_ok, n_rd_ok;
    logic [BYTE_W-1:0] r_rdata;
    logic              r_out_valid, n_out_valid;
    logic              w_load;

    logic              w_we;
    logic [AW:0]       w_waddr;
    logic [BYTE_W-1:0] w_wdata;
    logic              w_re;
    logic [AW:0]       w_raddr;
    logic [XW-1:0]     w_idx_ext;
    logic [XW-1:0]     w_cnt_ext;

    logic [BYTE_W-1:0]  r_o_data;
    logic               r_o_slot;
    logic [COUNT_W-1:0] r_o_count;
    logic               r_o_swap;
    logic               r_o_drop;

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_init_busy = r_clr_both;
    assign w_idx_ext   = XW'(i_cmd.idx);
    assign w_cnt_ext   = XW'(r_cnt[r_active]);

    // Sequencer: execute one command, sweep a slot when it is cleared, then post the result.
    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_rel       = r_rel;
        n_cnt       = r_cnt;
        n_clr_slot  = r_clr_slot;
        n_clr_both  = r_clr_both;
        n_clr_ptr   = r_clr_ptr;
        n_swap      = r_swap;
        n_drop      = r_drop;
        n_rd_ok     = r_rd_ok;
        w_we        = 1'b0;
        w_waddr     = {r_clr_slot, r_clr_ptr};
        w_wdata     = '0;
        w_re        = 1'b0;
        w_raddr     = {i_cmd.sel, w_idx_ext[AW-1:0]};
        w_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_swap  = 1'b0;
                    n_drop  = 1'b0;
                    n_rd_ok = 1'b0;
                    n_state = ST_EMIT;
                    case (i_cmd.op)
                        OP_RX: begin
                            w_we    = 1'b1;
                            w_waddr = {r_active, r_cnt[r_active]};
                            w_wdata = i_cmd.data;
                            n_cnt[r_active] = (r_cnt[r_active] == LAST) ? '0
                                                                        : r_cnt[r_active] + 1'b1;
                        end
                        OP_DONE: begin
                            if (r_rel[~r_active]) begin
                                n_clr_slot       = ~r_active;
                                n_active         = ~r_active;
                                n_cnt[~r_active] = '0;
                                n_rel            = 2'b00;
                                n_swap           = 1'b1;
                            end else begin
                                n_clr_slot      = r_active;
                                n_cnt[r_active] = '0;
                                n_drop          = 1'b1;
                            end
                            n_clr_ptr  = '0;
                            n_clr_both = 1'b0;
                            n_state    = ST_CLEAR;
                        end
                        OP_RELEASE: begin
                            n_rel[i_cmd.sel] = 1'b1;
                        end
                        OP_READ: begin
                            w_re    = 1'b1;
                            n_rd_ok = i_cmd.read_ok;
                        end
                        OP_RESTART: begin
                            n_clr_slot = 1'b0;
                            n_cnt[0]   = '0;
                            n_cnt[1]   = '0;
                            n_rel      = 2'b10;
                            n_active   = 1'b0;
                            n_clr_ptr  = '0;
                            n_clr_both = 1'b0;
                            n_state    = ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                w_we = 1'b1;
                if (r_clr_ptr == LAST) begin
                    n_clr_ptr = '0;
                    if (r_clr_both && !r_clr_slot) begin
                        n_clr_slot = 1'b1;
                    end else if (r_clr_both) begin
                        n_clr_both = 1'b0;
                        n_state    = ST_IDLE;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end else begin
                    n_clr_ptr = r_clr_ptr + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && !o_out.ready) || w_load;
    end

    // Control state; reset starts with a sweep over both slots.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_active    <= 1'b0;
            r_rel       <= 2'b10;
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_clr_slot  <= 1'b0;
            r_clr_both  <= 1'b1;
            r_clr_ptr   <= '0;
            r_swap      <= 1'b0;
            r_drop      <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_rel       <= n_rel;
            r_cnt       <= n_cnt;
            r_clr_slot  <= n_clr_slot;
            r_clr_both  <= n_clr_both;
            r_clr_ptr   <= n_clr_ptr;
            r_swap      <= n_swap;
            r_drop      <= n_drop;
            r_rd_ok     <= n_rd_ok;
            r_out_valid <= n_out_valid;
        end
    end

    // Memory write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // Result register; the status fields reflect the state after the item.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_data  <= r_rd_ok ? r_rdata : '0;
            r_o_slot  <= r_active;
            r_o_count <= w_cnt_ext[COUNT_W-1:0];
            r_o_swap  <= r_swap;
            r_o_drop  <= r_drop;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.read_data    = r_o_data;
    assign o_out.current_slot = r_o_slot;
    assign o_out.fill_count   = r_o_count;
    assign o_out.swapped      = r_o_swap;
    assign o_out.dropped      = r_o_drop;

    // A swap moves to the other slot and leaves both slots unreleased.
    a_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_cmd_valid && i_cmd.op == OP_DONE && r_rel[~r_active])
        |=> (r_rel == 2'b00 && r_active != $past(r_active) && r_swap))
        else $error("slot swap did not take effect");

    // No result is posted during the power-up clear.
    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_both |-> !r_out_valid)
        else $error("result posted during power-up clear");

    // Fill counts never reach the slot size.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= LAST) && (r_cnt[1] <= LAST))
        else $error("fill count out of range");

endmodule

### hw/rtl/pingpong_rx_packet_buffer.sv
// Top level of the two-slot ping-pong receive buffer.
// Each word carries one action (receive byte, packet done, release slot, read byte, restart)
// and produces exactly one result word. A decoding front end and a two-entry command queue
// keep accepting words while the back end works. The back end executes a receive, release,
// read or unused code and then posts its result, plus any wait on the result channel;
// packet done and restart first sweep the cleared slot one byte per cycle through the single
// write port of the slot memory. After reset the memory of both slots is cleared, during
// which no input word is accepted.
module pingpong_rx_packet_buffer #(
    parameter int SLOT_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pprb_in_if.sink     i_in,
    pprb_out_if.source  o_out
);
    import pprb_pkg::*;

    logic w_fe_valid;
    logic w_fe_ready;
    t_cmd w_fe_cmd;
    logic w_q_valid;
    logic w_q_ready;
    t_cmd w_q_cmd;
    logic w_init_busy;

    pprb_front #(
        .SLOT_BYTES (SLOT_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_init_busy (w_init_busy),
        .o_cmd_valid (w_fe_valid),
        .i_cmd_ready (w_fe_ready),
        .o_cmd       (w_fe_cmd)
    );

    pprb_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fe_valid),
        .o_ready (w_fe_ready),
        .i_cmd   (w_fe_cmd),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_cmd   (w_q_cmd)
    );

    pprb_back #(
        .SLOT_BYTES (SLOT_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd       (w_q_cmd),
        .o_init_busy (w_init_busy),
        .o_out       (o_out)
    );

endmodule

### test/pingpong_rx_packet_buffer_test.sv
// Self-checking testbench of the ping-pong receive buffer with random handshake timing.
module pingpong_rx_packet_buffer_test;
    import pprb_pkg::*;

    localparam int SLOT_BYTES = 64;
    localparam int RANDOM_WORDS = 1000;
    localparam int MAX_GAP = 10;
    localparam int HOLD_AT = 300;
    localparam int HOLD_LEN = 400;
    localparam int TAIL_CYCLES = 100;
    localparam int IDLE_LIMIT = 2000;

    // Action codes that the block leaves without effect.
    localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   rx_byte;
        logic                slot_select;
        logic [INDEX_W-1:0]  read_index;
    } t_word;

    typedef struct packed {
        logic [BYTE_W-1:0]  read_data;
        logic               current_slot;
        logic [COUNT_W-1:0] fill_count;
        logic               swapped;
        logic               dropped;
    } t_status;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Driven copies of the channel inputs, known from time zero.
    logic                drv_valid = 1'b0;
    logic [ACTION_W-1:0] drv_action = '0;
    logic [BYTE_W-1:0]   drv_byte = '0;
    logic                drv_sel = 1'b0;
    logic [INDEX_W-1:0]  drv_index = '0;
    logic                drv_ready = 1'b0;

    pprb_in_if  in_ch ();
    pprb_out_if out_ch ();

    assign in_ch.valid       = drv_valid;
    assign in_ch.action      = drv_action;
    assign in_ch.rx_byte     = drv_byte;
    assign in_ch.slot_select = drv_sel;
    assign in_ch.read_index  = drv_index;
    assign out_ch.ready      = drv_ready;

    pingpong_rx_packet_buffer #(
        .SLOT_BYTES(SLOT_BYTES)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_word   pending_words[$];
    t_status expected_status[$];
    int      words_accepted = 0;
    int      results_seen = 0;
    int      error_count = 0;
    logic    in_taken = 1'b0;
    logic    out_taken = 1'b0;

    // Predicted buffer contents and bookkeeping after reset.
    logic [BYTE_W-1:0] pred_bytes [2][SLOT_BYTES] = '{default: '0};
    int unsigned       pred_count [2] = '{0, 0};
    logic              pred_free [2] = '{1'b0, 1'b1};
    logic              pred_slot = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void wipe_slot(input logic s);
        for (int k = 0; k < SLOT_BYTES; k++) begin
            pred_bytes[s][k] = '0;
        end
    endfunction

    // Apply one word to the predicted buffer and return the status word it yields.
    task automatic predict_status(input t_word w, output t_status r);
        logic cur;
        logic oth;
        r = '0;
        cur = pred_slot;
        oth = ~cur;
        case (w.action)
            ACT_RX: begin
                if (pred_count[cur] < SLOT_BYTES) begin
                    pred_bytes[cur][pred_count[cur]] = w.rx_byte;
                end
                pred_count[cur] = (pred_count[cur] + 1 >= SLOT_BYTES) ? 0 : pred_count[cur] + 1;
            end
            ACT_DONE: begin
                if (pred_free[oth]) begin
                    wipe_slot(oth);
                    pred_slot = oth;
                    pred_count[oth] = 0;
                    pred_free[0] = 1'b0;
                    pred_free[1] = 1'b0;
                    r.swapped = 1'b1;
                end else begin
                    wipe_slot(cur);
                    pred_count[cur] = 0;
                    r.dropped = 1'b1;
                end
            end
            ACT_RELEASE: begin
                pred_free[w.slot_select] = 1'b1;
            end
            ACT_READ: begin
                if (w.read_index < SLOT_BYTES) begin
                    r.read_data = pred_bytes[w.slot_select][w.read_index];
                end
            end
            ACT_RESTART: begin
                wipe_slot(1'b0);
                pred_count[0] = 0;
                pred_count[1] = 0;
                pred_free[0] = 1'b0;
                pred_free[1] = 1'b1;
                pred_slot = 1'b0;
            end
            default: begin
            end
        endcase
        r.current_slot = pred_slot;
        r.fill_count = COUNT_W'(pred_count[pred_slot]);
    endtask

    task automatic add_word(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b,
                            input logic s, input logic [INDEX_W-1:0] ix, inout int counted);
        t_word w;
        w.action = act;
        w.rx_byte = b;
        w.slot_select = s;
        w.read_index = ix;
        pending_words.push_back(w);
        if (act <= ACT_RESTART) begin
            counted++;
        end
    endtask

    // Sender: offers words from the pending queue with a random gap after each one.
    int   send_gap = 0;
    logic send_calm = 1'b0;

    always @(negedge i_clk) begin : word_driver
        t_word nxt;
        if (i_rst_n) begin
            if (!drv_valid || in_taken) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    drv_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    nxt = pending_words.pop_front();
                    drv_action <= nxt.action;
                    drv_byte <= nxt.rx_byte;
                    drv_sel <= nxt.slot_select;
                    drv_index <= nxt.read_index;
                    drv_valid <= 1'b1;
                    send_gap <= send_calm ? 0 : $urandom_range(0, MAX_GAP);
                    if ($urandom_range(0, 29) == 0) begin
                        send_calm <= ~send_calm;
                    end
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random wait after each result word, and one long hold-off.
    int   recv_wait = 0;
    int   hold_left = 0;
    logic recv_calm = 1'b0;

    always @(negedge i_clk) begin : result_receiver
        int gap;
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                drv_ready <= 1'b0;
            end else if (out_taken && results_seen == HOLD_AT) begin
                hold_left <= HOLD_LEN;
                drv_ready <= 1'b0;
            end else if (out_taken) begin
                gap = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
                recv_wait <= gap;
                drv_ready <= (gap == 0);
                if ($urandom_range(0, 29) == 0) begin
                    recv_calm <= ~recv_calm;
                end
            end else if (!drv_ready) begin
                if (recv_wait > 1) begin
                    recv_wait <= recv_wait - 1;
                end else begin
                    drv_ready <= 1'b1;
                end
            end
        end
    end

    // Predict on every accepted input word and check every accepted result word.
    always @(posedge i_clk) begin : status_monitor
        t_word   w;
        t_status e;
        t_status g;
        in_taken <= in_ch.valid && in_ch.ready;
        out_taken <= out_ch.valid && out_ch.ready;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                w.action = in_ch.action;
                w.rx_byte = in_ch.rx_byte;
                w.slot_select = in_ch.slot_select;
                w.read_index = in_ch.read_index;
                predict_status(w, e);
                expected_status.push_back(e);
                words_accepted++;
            end
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                g.read_data = out_ch.read_data;
                g.current_slot = out_ch.current_slot;
                g.fill_count = out_ch.fill_count;
                g.swapped = out_ch.swapped;
                g.dropped = out_ch.dropped;
                if (expected_status.size() == 0) begin
                    $error("result word with no expected status waiting");
                    error_count++;
                end else begin
                    e = expected_status.pop_front();
                    if (g.read_data !== e.read_data) begin
                        $error("read_data expected %0d got %0d", e.read_data, g.read_data);
                        error_count++;
                    end
                    if (g.current_slot !== e.current_slot) begin
                        $error("current_slot expected %0d got %0d", e.current_slot,
                               g.current_slot);
                        error_count++;
                    end
                    if (g.fill_count !== e.fill_count) begin
                        $error("fill_count expected %0d got %0d", e.fill_count, g.fill_count);
                        error_count++;
                    end
                    if (g.swapped !== e.swapped) begin
                        $error("swapped expected %0d got %0d", e.swapped, g.swapped);
                        error_count++;
                    end
                    if (g.dropped !== e.dropped) begin
                        $error("dropped expected %0d got %0d", e.dropped, g.dropped);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no word moves on either channel for too long.
    int idle_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("FAIL pingpong_rx_packet_buffer");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int directed_count;
        int random_count;
        int pick;
        int len;
        int total;
        directed_count = 0;
        random_count = 0;

        // Directed words: byte extremes, reads inside and past the packet, a swap, a drop,
        // double release, spare codes, and a restart that keeps slot 1 data.
        add_word(ACT_RX, 8'h00, 1'b1, 6'd63, directed_count);
        add_word(ACT_RX, 8'hFF, 1'b0, 6'd0, directed_count);
        add_word(ACT_RX, 8'h5A, 1'b1, 6'd42, directed_count);
        add_word(ACT_READ, 8'hFF, 1'b0, 6'd0, directed_count);
        add_word(ACT_READ, 8'h00, 1'b0, 6'd1, directed_count);
        add_word(ACT_READ, 8'hAA, 1'b0, 6'd63, directed_count);
        add_word(ACT_READ, 8'h55, 1'b1, 6'd0, directed_count);
        add_word(ACT_DONE, 8'h00, 1'b0, 6'd0, directed_count);
        add_word(ACT_RX, 8'h81, 1'b0, 6'd21, directed_count);
        add_word(ACT_DONE, 8'hFF, 1'b1, 6'd63, directed_count);
        add_word(ACT_RELEASE, 8'h00, 1'b0, 6'd0, directed_count);
        add_word(ACT_RELEASE, 8'h00, 1'b0, 6'd7, directed_count);
        add_word(ACT_RX, 8'h3C, 1'b0, 6'd0, directed_count);
        add_word(ACT_DONE, 8'h00, 1'b0, 6'd0, directed_count);
        add_word(ACT_READ, 8'h00, 1'b1, 6'd0, directed_count);
        add_word(ACT_SPARE_LO, 8'hFF, 1'b1, 6'd63, directed_count);
        add_word(ACT_SPARE_HI, 8'h00, 1'b0, 6'd0, directed_count);
        add_word(ACT_RESTART, 8'hFF, 1'b1, 6'd63, directed_count);
        add_word(ACT_READ, 8'h00, 1'b1, 6'd0, directed_count);
        add_word(ACT_READ, 8'h00, 1'b0, 6'd0, directed_count);
        add_word(ACT_RELEASE, 8'h00, 1'b1, 6'd0, directed_count);
        add_word(ACT_DONE, 8'h00, 1'b0, 6'd0, directed_count);

        // Random part: mostly whole packets followed by host reads and releases.
        while (random_count < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                                  : $urandom_range(0, 12);
                repeat (len) begin
                    add_word(ACT_RX, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             INDEX_W'($urandom_range(0, 63)), random_count);
                end
                add_word(ACT_DONE, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         INDEX_W'($urandom_range(0, 63)), random_count);
                repeat ($urandom_range(0, 4)) begin
                    add_word(ACT_READ, BYTE_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)),
                             INDEX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                                  : $urandom_range(0, 15)),
                             random_count);
                end
                if ($urandom_range(0, 2) != 0) begin
                    add_word(ACT_RELEASE, BYTE_W'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), INDEX_W'($urandom_range(0, 63)),
                             random_count);
                end
            end else if (pick < 80) begin
                add_word(ACT_RESTART, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         INDEX_W'($urandom_range(0, 63)), random_count);
            end else begin
                // Noise: any action code, spare ones included.
                add_word(ACTION_W'($urandom_range(0, 7)), BYTE_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), INDEX_W'($urandom_range(0, 63)),
                         random_count);
            end
        end
        total = pending_words.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (words_accepted < total || expected_status.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_status.size() == 0) begin
            $display("PASS pingpong_rx_packet_buffer");
        end else begin
            $display("FAIL pingpong_rx_packet_buffer");
        end
        $finish;
    end

endmodule
